// ===== sv/rcf_pkg.sv =====
// Shared types, register indexes and the sample test for the range clip flagger.
package rcf_pkg;

	localparam int DATA_W    = 32;
	localparam int CFG_IDX_W = 3;
	localparam int JOB_DEPTH = 2;
	localparam int JOB_PTR_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_RANGE_ENABLED   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_OUTSIDE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_ZEROS      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_AVERAGE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_MIN        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_MAX        = 3'd5;

	typedef struct packed {
		logic                     range_enabled;
		logic                     clip_outside;
		logic                     clip_zeros;
		logic                     channel_average;
		logic signed [DATA_W-1:0] clip_min;
		logic signed [DATA_W-1:0] clip_max;
	} cfg_t;

	// Control part of a job handed from the front end to the back end.
	typedef struct packed {
		logic is_row;    // row-average job rather than a per-channel result
		logic flag;      // per-channel verdict, already worked out
		logic nan_seen;  // a counted sample of the row was NaN
	} job_ctrl_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_FINISH
	} bk_state_t;

	// Flag test applied to a single sample or to a row average.
	function automatic logic flag_test(logic signed [DATA_W-1:0] v, logic is_nan, cfg_t cfg);
		logic in_range;
		logic hit;
		in_range = (v >= cfg.clip_min) && (v <= cfg.clip_max);
		hit = is_nan;
		if (cfg.range_enabled && (cfg.clip_outside ? !in_range : in_range)) begin
			hit = 1'b1;
		end
		if (cfg.clip_zeros && (v == '0)) begin
			hit = 1'b1;
		end
		return hit;
	endfunction

endpackage

// ===== sv/range_clip_flagger.sv =====
// Top level of the range clip flagger: registers, front end, job queue and back end.
//
//  channel   direction  handshake        beat carries
//  --------  ---------  ---------------  -----------------------------------------------
//  samples   in         push / full      sample_value, sample_is_nan, already_flagged,
//                                        row_end
//  results   out        empty / pop      flag, whole_row
//  config    in         cfg_we           cfg_index, cfg_data
//
// A per-channel beat passes the front end combinationally into the job queue and from there
// into the result register; per-channel samples stream at one beat per cycle while results
// are taken. A row-average result passes the back end's divider, one quotient bit per cycle,
// and then the final test; the two-entry job queue lets the front end keep taking samples
// meanwhile. Reset clears the registers, the row accumulators, the queue and the result
// valid bit; no clearing pass is needed. Either side may stall freely: full rises only when
// the job queue is full, and a held result stalls the back end until a pop frees the slot.
module range_clip_flagger
	import rcf_pkg::*;
#(
	parameter int MAX_CHANNELS = 4096
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [DATA_W-1:0]        cfg_data,
	input  logic                     push,
	output logic                     full,
	input  logic signed [DATA_W-1:0] sample_value,
	input  logic                     sample_is_nan,
	input  logic                     already_flagged,
	input  logic                     row_end,
	output logic                     empty,
	input  logic                     pop,
	output logic                     flag,
	output logic                     whole_row
);

	// The sum needs room for MAX_CHANNELS samples; the count must hold MAX_CHANNELS itself.
	localparam int SUM_W = DATA_W + $clog2(MAX_CHANNELS);
	localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
	localparam int JOB_W = $bits(job_ctrl_t) + CNT_W + SUM_W;

	cfg_t cfg_q;

	logic             job_wr;
	logic             job_rd;
	logic             job_full;
	logic             job_empty;
	job_ctrl_t        wr_ctrl;
	logic [CNT_W-1:0] wr_count;
	logic [SUM_W-1:0] wr_sum;
	job_ctrl_t        rd_ctrl;
	logic [CNT_W-1:0] rd_count;
	logic [SUM_W-1:0] rd_sum;
	logic [JOB_W-1:0] job_wdata;
	logic [JOB_W-1:0] job_rdata;

	// Configuration registers. Writes to indexes past the last register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_enabled   <= 1'b0;
			cfg_q.clip_outside    <= 1'b1;
			cfg_q.clip_zeros      <= 1'b0;
			cfg_q.channel_average <= 1'b0;
			cfg_q.clip_min        <= '0;
			cfg_q.clip_max        <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RANGE_ENABLED:   cfg_q.range_enabled   <= cfg_data[0];
				REG_CLIP_OUTSIDE:    cfg_q.clip_outside    <= cfg_data[0];
				REG_CLIP_ZEROS:      cfg_q.clip_zeros      <= cfg_data[0];
				REG_CHANNEL_AVERAGE: cfg_q.channel_average <= cfg_data[0];
				REG_CLIP_MIN:        cfg_q.clip_min        <= cfg_data;
				REG_CLIP_MAX:        cfg_q.clip_max        <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The front end stalls the sample channel only when the job queue cannot take a job.
	assign full = job_full;

	rcf_front #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.SUM_W        (SUM_W),
		.CNT_W        (CNT_W)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.push            (push),
		.sample_value    (sample_value),
		.sample_is_nan   (sample_is_nan),
		.already_flagged (already_flagged),
		.row_end         (row_end),
		.job_full        (job_full),
		.job_wr          (job_wr),
		.job_ctrl        (wr_ctrl),
		.job_count       (wr_count),
		.job_sum         (wr_sum)
	);

	assign job_wdata = {wr_ctrl, wr_count, wr_sum};
	assign {rd_ctrl, rd_count, rd_sum} = job_rdata;

	rcf_job_fifo #(
		.WIDTH (JOB_W)
	) u_job_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_wr),
		.wdata  (job_wdata),
		.rd     (job_rd),
		.rdata  (job_rdata),
		.full   (job_full),
		.empty  (job_empty)
	);

	rcf_back #(
		.SUM_W (SUM_W),
		.CNT_W (CNT_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_empty (job_empty),
		.job_ctrl  (rd_ctrl),
		.job_count (rd_count),
		.job_sum   (rd_sum),
		.job_rd    (job_rd),
		.pop       (pop),
		.empty     (empty),
		.flag      (flag),
		.whole_row (whole_row)
	);

`ifndef SYNTHESIS
	// The front end never writes a job into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) job_wr |-> !job_full)
		else $error("job written into a full queue");

	// The back end never takes a job from an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n) job_rd |-> !job_empty)
		else $error("job read from an empty queue");

	// A row job always carries a non-zero count, so the divider never sees zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(job_wr && wr_ctrl.is_row) |-> (wr_count != '0))
		else $error("row job issued with zero count");

	// A per-channel job only arrives from a beat taken in per-channel mode.
	assert property (@(posedge clk) disable iff (!arst_n)
		(job_wr && !wr_ctrl.is_row) |-> (push && !full && !cfg_q.channel_average))
		else $error("per-channel job without a matching sample beat");
`endif

endmodule

// ===== sv/rcf_job_fifo.sv =====
// Two-entry job queue between the front end and the back end.
module rcf_job_fifo
	import rcf_pkg::*;
#(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	logic [WIDTH-1:0]   mem_q [JOB_DEPTH];
	logic [JOB_PTR_W-1:0] wr_ptr_q;
	logic [JOB_PTR_W-1:0] rd_ptr_q;
	logic [JOB_PTR_W:0]   fill_q;

	assign full  = (fill_q == (JOB_PTR_W+1)'(JOB_DEPTH));
	assign empty = (fill_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				fill_q <= fill_q + 1'b1;
			end else if (rd && !wr) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/rcf_front.sv =====
// Front end: takes samples, runs the row accumulators and issues jobs.
module rcf_front
	import rcf_pkg::*;
#(
	parameter int MAX_CHANNELS = 4096,
	parameter int SUM_W        = 44,
	parameter int CNT_W        = 13
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  logic                     push,
	input  logic signed [DATA_W-1:0] sample_value,
	input  logic                     sample_is_nan,
	input  logic                     already_flagged,
	input  logic                     row_end,
	input  logic                     job_full,
	output logic                     job_wr,
	output job_ctrl_t                job_ctrl,
	output logic [CNT_W-1:0]         job_count,
	output logic [SUM_W-1:0]         job_sum
);

	logic signed [SUM_W-1:0] row_sum_q;
	logic [CNT_W-1:0]        row_count_q;
	logic                    row_nan_q;

	logic                    accept;
	logic                    add;
	logic signed [SUM_W-1:0] addend;
	logic signed [SUM_W-1:0] sum_next;
	logic [CNT_W-1:0]        count_next;
	logic                    nan_next;

	assign accept = push && !job_full;

	// Samples past the channel limit of a row are neither summed nor counted.
	assign add        = cfg.channel_average && !already_flagged &&
	                    (row_count_q < CNT_W'(MAX_CHANNELS));
	assign addend     = (add && !sample_is_nan) ? SUM_W'(sample_value) : '0;
	assign sum_next   = row_sum_q + addend;
	assign count_next = row_count_q + CNT_W'(add);
	assign nan_next   = row_nan_q | (add & sample_is_nan);

	assign job_wr = accept && (!cfg.channel_average || (row_end && (count_next != '0)));

	always_comb begin
		job_ctrl.is_row   = cfg.channel_average;
		job_ctrl.flag     = flag_test(sample_value, sample_is_nan, cfg);
		job_ctrl.nan_seen = nan_next;
	end

	assign job_count = count_next;
	assign job_sum   = sum_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_sum_q   <= '0;
			row_count_q <= '0;
			row_nan_q   <= 1'b0;
		end else if (accept) begin
			if (row_end) begin
				row_sum_q   <= '0;
				row_count_q <= '0;
				row_nan_q   <= 1'b0;
			end else begin
				row_sum_q   <= sum_next;
				row_count_q <= count_next;
				row_nan_q   <= nan_next;
			end
		end
	end

endmodule

// ===== sv/rcf_back.sv =====
// Back end: row-average division, final test and the result register.
module rcf_back
	import rcf_pkg::*;
#(
	parameter int SUM_W = 44,
	parameter int CNT_W = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             job_empty,
	input  job_ctrl_t        job_ctrl,
	input  logic [CNT_W-1:0] job_count,
	input  logic [SUM_W-1:0] job_sum,
	output logic             job_rd,
	input  logic             pop,
	output logic             empty,
	output logic             flag,
	output logic             whole_row
);

	localparam int STEP_W = $clog2(SUM_W);

	bk_state_t         state_q;
	bk_state_t         state_d;
	logic [SUM_W-1:0]  acc_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  div_q;
	logic              neg_q;
	logic [STEP_W-1:0] step_q;
	logic              res_valid_q;
	logic              res_flag_q;
	logic              res_whole_q;

	logic                     slot_free;
	logic                     load_div;
	logic                     res_load;
	logic                     res_flag_d;
	logic                     res_whole_d;
	logic [CNT_W:0]           rem_sh;
	logic [CNT_W-1:0]         rem_diff;
	logic                     q_bit;
	logic signed [DATA_W-1:0] avg;

	assign slot_free = !res_valid_q || pop;

	// One quotient bit per cycle, restoring form. When the divisor fits, the new remainder is
	// below the divisor, so the low bits of the difference hold it exactly.
	assign rem_sh   = {rem_q, acc_q[SUM_W-1]};
	assign rem_diff = rem_sh[CNT_W-1:0] - div_q;
	assign q_bit    = (rem_sh >= {1'b0, div_q});

	// The average of 32-bit samples always fits in 32 bits.
	assign avg = neg_q ? -acc_q[DATA_W-1:0] : acc_q[DATA_W-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!job_empty && job_ctrl.is_row && !job_ctrl.nan_seen) begin
					state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				if (step_q == '0) begin
					state_d = BK_FINISH;
				end
			end
			BK_FINISH: begin
				if (slot_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		job_rd      = 1'b0;
		load_div    = 1'b0;
		res_load    = 1'b0;
		res_flag_d  = 1'b0;
		res_whole_d = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!job_empty) begin
					priority if (!job_ctrl.is_row) begin
						job_rd      = slot_free;
						res_load    = slot_free;
						res_flag_d  = job_ctrl.flag;
					end else if (job_ctrl.nan_seen) begin
						job_rd      = slot_free;
						res_load    = slot_free;
						res_flag_d  = 1'b1;
						res_whole_d = 1'b1;
					end else begin
						job_rd   = 1'b1;
						load_div = 1'b1;
					end
				end
			end
			BK_DIV: begin
			end
			BK_FINISH: begin
				res_load    = slot_free;
				res_flag_d  = flag_test(avg, 1'b0, cfg);
				res_whole_d = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_div) begin
			neg_q  <= job_sum[SUM_W-1];
			acc_q  <= job_sum[SUM_W-1] ? -job_sum : job_sum;
			rem_q  <= '0;
			div_q  <= job_count;
			step_q <= STEP_W'(SUM_W-1);
		end else if (state_q == BK_DIV) begin
			rem_q  <= q_bit ? rem_diff : rem_sh[CNT_W-1:0];
			acc_q  <= {acc_q[SUM_W-2:0], q_bit};
			step_q <= step_q - 1'b1;
		end
		if (res_load) begin
			res_flag_q  <= res_flag_d;
			res_whole_q <= res_whole_d;
		end
	end

	assign empty     = !res_valid_q;
	assign flag      = res_flag_q;
	assign whole_row = res_whole_q;

endmodule
